// ===== rtl/smtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_pkg
// Shared constants and types of the sliding-mode torque controller.
// ----------------------------------------------------------------------------
package smtc_pkg;

    localparam int FIELD_W   = 32;
    localparam int EPS_W     = 31;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLIDING_SLOPE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCHING_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_INERTIA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORSION_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_VEL_COEFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_DAMPING_RATIO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_WIDTH     = 3'd6;

    // 0.1 in unsigned Q15.16
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd6554;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/smtc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_in_if / smtc_out_if
// Valid/ready channels for control samples and torque results.
// ----------------------------------------------------------------------------
interface smtc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] torque_ref;
    logic signed [31:0] torque_ref_rate;
    logic signed [31:0] torque_ref_accel;
    logic signed [31:0] measured_torsion;
    logic signed [31:0] torsion_rate;
    logic signed [31:0] motor_velocity;

    modport source (output valid, torque_ref, torque_ref_rate, torque_ref_accel,
                    measured_torsion, torsion_rate, motor_velocity, input ready);
    modport sink   (input valid, torque_ref, torque_ref_rate, torque_ref_accel,
                    measured_torsion, torsion_rate, motor_velocity, output ready);
endinterface

interface smtc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_torque;
    logic signed [31:0] sliding_surface;

    modport source (output valid, drive_torque, sliding_surface, input ready);
    modport sink   (input valid, drive_torque, sliding_surface, output ready);
endinterface
`default_nettype wire

// ===== rtl/smtc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_mul
// Registered fixed-point multiply, rounded half away from zero, saturated.
// ----------------------------------------------------------------------------
module smtc_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [W-1:0] a,
    input  wire logic signed [W-1:0] b,
    output logic signed [W-1:0]      y
);

    localparam int PW = 2 * W + 1;
    localparam int MW = PW - F;

    logic                neg;
    logic [W-1:0]        ma;
    logic [W-1:0]        mb;
    logic [PW-1:0]       prod;
    logic [MW-1:0]       mag;
    logic [MW-1:0]       lim;
    logic signed [W-1:0] y_next;

    // magnitude product, round, clamp
    always_comb
    begin
        neg  = a[W-1] ^ b[W-1];
        ma   = a[W-1] ? W'(-a) : W'(a);
        mb   = b[W-1] ? W'(-b) : W'(b);
        prod = PW'(ma) * PW'(mb) + (PW'(1) << (F - 1));
        mag  = prod[PW-1:F];
        lim  = MW'(1) << (W - 1);
        if (mag > lim)
        begin
            mag = lim;
        end
        if (neg)
        begin
            y_next = W'(-mag[W-1:0]);
            if (mag == lim)
            begin
                y_next = {1'b1, {(W-1){1'b0}}};
            end
        end
        else if (mag >= lim)
        begin
            y_next = {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            y_next = mag[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y <= y_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smtc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_front
// Takes samples, forms error, error rate, sliding surface and the
// equivalent-control sum; hands sigma and the sum to the queue.
// ----------------------------------------------------------------------------
module smtc_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    smtc_in_if.sink                  sample_in,
    input  wire logic signed [W-1:0] slope,
    input  wire logic signed [W-1:0] w1,
    input  wire logic signed [W-1:0] w2,
    input  wire logic signed [W-1:0] bl,
    input  wire smtc_pkg::q_status_t qstat,
    output logic                     push,
    output logic signed [W-1:0]      sigma,
    output logic signed [W-1:0]      eq
);
    import smtc_pkg::*;

    localparam int XW = (W > FIELD_W) ? W : FIELD_W;

    function automatic logic signed [W-1:0] sat_in(input logic [FIELD_W-1:0] x);
        logic signed [XW-1:0] xe;
        logic [XW-W:0]        top;
        xe  = XW'(signed'(x));
        top = xe[XW-1:W-1];
        if (&top || ~|top)
        begin
            return xe[W-1:0];
        end
        return xe[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] s);
        if (s[W] != s[W-1])
        begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    logic                en;
    logic [6:1]          vld_reg;

    // stage 1
    logic signed [W-1:0] e_reg, ed_reg, tq_reg, tqd_reg, vm_reg, refdd_reg;
    // stage 2 (products come from the multipliers)
    logic signed [W-1:0] pce, pw1, pw2, pbl, pced;
    logic signed [W-1:0] ed2_reg, refdd2_reg;
    // stage 3..6
    logic signed [W-1:0] sig3_reg, eq3_reg, pw2_3_reg, pbl3_reg, pced3_reg;
    logic signed [W-1:0] sig4_reg, eq4_reg, pbl4_reg, pced4_reg;
    logic signed [W-1:0] sig5_reg, eq5_reg, pced5_reg;
    logic signed [W-1:0] sig6_reg, eq6_reg;
    logic signed [W-1:0] ref_s, tq_s, refd_s, tqd_s;

    assign en              = !(vld_reg[6] && qstat.full);
    assign sample_in.ready = en;
    assign push            = vld_reg[6] && !qstat.full;
    assign sigma           = sig6_reg;
    assign eq              = eq6_reg;

    assign ref_s  = sat_in(sample_in.torque_ref);
    assign tq_s   = sat_in(sample_in.measured_torsion);
    assign refd_s = sat_in(sample_in.torque_ref_rate);
    assign tqd_s  = sat_in(sample_in.torsion_rate);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:1], sample_in.valid};
        end
    end

    // error and error rate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg     <= sat_add({ref_s[W-1], ref_s} - {tq_s[W-1], tq_s});
            ed_reg    <= sat_add({refd_s[W-1], refd_s} - {tqd_s[W-1], tqd_s});
            tq_reg    <= tq_s;
            tqd_reg   <= tqd_s;
            vm_reg    <= sat_in(sample_in.motor_velocity);
            refdd_reg <= sat_in(sample_in.torque_ref_accel);
        end
    end

    // products, all in parallel
    smtc_mul #(.W(W), .F(F)) u_mul_ce  (.clk(clk), .en(en), .a(slope), .b(e_reg),   .y(pce));
    smtc_mul #(.W(W), .F(F)) u_mul_w1  (.clk(clk), .en(en), .a(w1),    .b(tq_reg),  .y(pw1));
    smtc_mul #(.W(W), .F(F)) u_mul_w2  (.clk(clk), .en(en), .a(w2),    .b(vm_reg),  .y(pw2));
    smtc_mul #(.W(W), .F(F)) u_mul_bl  (.clk(clk), .en(en), .a(bl),    .b(tqd_reg), .y(pbl));
    smtc_mul #(.W(W), .F(F)) u_mul_ced (.clk(clk), .en(en), .a(slope), .b(ed_reg),  .y(pced));

    // surface and the saturating equivalent-term chain, one add a stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ed2_reg    <= ed_reg;
            refdd2_reg <= refdd_reg;

            sig3_reg   <= sat_add({ed2_reg[W-1], ed2_reg} + {pce[W-1], pce});
            eq3_reg    <= sat_add({refdd2_reg[W-1], refdd2_reg} - {pw1[W-1], pw1});
            pw2_3_reg  <= pw2;
            pbl3_reg   <= pbl;
            pced3_reg  <= pced;

            sig4_reg   <= sig3_reg;
            eq4_reg    <= sat_add({eq3_reg[W-1], eq3_reg} + {pw2_3_reg[W-1], pw2_3_reg});
            pbl4_reg   <= pbl3_reg;
            pced4_reg  <= pced3_reg;

            sig5_reg   <= sig4_reg;
            eq5_reg    <= sat_add({eq4_reg[W-1], eq4_reg} + {pbl4_reg[W-1], pbl4_reg});
            pced5_reg  <= pced4_reg;

            sig6_reg   <= sig5_reg;
            eq6_reg    <= sat_add({eq5_reg[W-1], eq5_reg} + {pced5_reg[W-1], pced5_reg});
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smtc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_queue
// Four-entry queue of (sigma, equivalent sum) between front and back.
// ----------------------------------------------------------------------------
module smtc_queue #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic signed [W-1:0] sigma_in,
    input  wire logic signed [W-1:0] eq_in,
    input  wire logic                pop,
    output logic signed [W-1:0]      sigma_out,
    output logic signed [W-1:0]      eq_out,
    output smtc_pkg::q_status_t      qstat
);
    import smtc_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [2*W-1:0] mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign qstat.full  = (count_reg == (AW+1)'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign {sigma_out, eq_out} = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {sigma_in, eq_in};
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
    a_count_dn: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ===== rtl/smtc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_back
// Boundary-layer switching fraction (pipelined restoring divider, one
// quotient bit a stage), switching and equivalent products, final sum.
// ----------------------------------------------------------------------------
module smtc_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire smtc_pkg::q_status_t    qstat,
    input  wire logic signed [W-1:0]    sigma_q,
    input  wire logic signed [W-1:0]    eq_q,
    output logic                        pop,
    input  wire logic signed [W-1:0]    gain,
    input  wire logic signed [W-1:0]    inertia,
    input  wire logic [smtc_pkg::EPS_W-1:0] eps,
    smtc_out_if.source                  torque_out
);
    import smtc_pkg::*;

    localparam int DW = ((W > EPS_W) ? W : EPS_W) + 1;
    localparam int OW = (W > FIELD_W) ? W : FIELD_W;

    function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [W-1:0] y);
        logic signed [OW-1:0] ye;
        logic [OW-FIELD_W:0]  top;
        ye  = OW'(y);
        top = ye[OW-1:FIELD_W-1];
        if (&top || ~|top)
        begin
            return ye[FIELD_W-1:0];
        end
        return ye[OW-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] s);
        if (s[W] != s[W-1])
        begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    logic                en;
    logic [F+2:0]        vld_reg;
    logic [DW-1:0]       r_reg   [F+1];
    logic [DW-1:0]       d_reg   [F+1];
    logic [F-1:0]        q_reg   [F+1];
    logic [F:0]          neg_reg;
    logic [F:0]          dz_reg;
    logic signed [W-1:0] sig_reg [F+2];
    logic signed [W-1:0] pj_reg  [1:F+1];
    logic signed [W-1:0] pj;
    logic signed [W-1:0] sw;
    logic signed [W-1:0] qs;
    logic [F-1:0]        q_fin;
    logic [W-1:0]        m;
    logic signed [FIELD_W-1:0] drive_reg, sig_out_reg;

    assign en                    = !vld_reg[F+2] || torque_out.ready;
    assign pop                   = en && !qstat.empty;
    assign torque_out.valid      = vld_reg[F+2];
    assign torque_out.drive_torque    = drive_reg;
    assign torque_out.sliding_surface = sig_out_reg;

    assign m = sigma_q[W-1] ? W'(-sigma_q) : W'(sigma_q);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[F+1:0], pop};
        end
    end

    // divider setup: magnitude and divisor |sigma| + eps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= DW'(m);
            d_reg[0]   <= DW'(m) + DW'(eps);
            dz_reg[0]  <= (m == '0) && (eps == '0);
            neg_reg[0] <= sigma_q[W-1];
            q_reg[0]   <= '0;
            sig_reg[0] <= sigma_q;
        end
    end

    // equivalent product runs beside the divider
    smtc_mul #(.W(W), .F(F)) u_mul_jm (.clk(clk), .en(en), .a(inertia), .b(eq_q), .y(pj));

    // one quotient bit per stage
    for (genvar k = 0; k < F; k++)
    begin : g_div
        logic [DW:0] rs;
        logic        ge;
        assign rs = {r_reg[k], 1'b0};
        assign ge = rs >= {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= ge ? DW'(rs - {1'b0, d_reg[k]}) : rs[DW-1:0];
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= {q_reg[k][F-2:0], ge};
                neg_reg[k+1] <= neg_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                sig_reg[k+1] <= sig_reg[k];
                pj_reg[k+1]  <= (k == 0) ? pj : pj_reg[(k == 0) ? 1 : k];
            end
        end
    end

    // signed fraction into the switching product
    assign q_fin = dz_reg[F] ? '0 : q_reg[F];
    assign qs    = neg_reg[F] ? -W'(q_fin) : W'(q_fin);

    smtc_mul #(.W(W), .F(F)) u_mul_p (.clk(clk), .en(en), .a(gain), .b(qs), .y(sw));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sig_reg[F+1] <= sig_reg[F];
            pj_reg[F+1]  <= pj_reg[F];
        end
    end

    // final sum and field saturation, output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drive_reg   <= sat_out(sat_add({sw[W-1], sw} + {pj_reg[F+1][W-1], pj_reg[F+1]}));
            sig_out_reg <= sat_out(sig_reg[F+1]);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sliding_mode_torque_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_mode_torque_control
// Sliding-mode torque law with a boundary layer, one sample in, one out.
// ----------------------------------------------------------------------------
// Takes one control sample per clock unless a full queue holds the front,
// and returns one result per sample, in order. The path is six front stages
// (error, five products in parallel, then the saturating equivalent-term
// adds one per stage), a four-entry queue, and the back pipeline whose
// length is set by the switching-fraction divider, which resolves one
// quotient bit per stage, followed by the gain product and the output
// register. Registers are written through cfg_we/cfg_index/cfg_data; indexes
// beyond the list are ignored. All arithmetic saturates; nothing wraps.
module sliding_mode_torque_control #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [smtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [smtc_pkg::FIELD_W-1:0]   cfg_data,
    smtc_in_if.sink                             sample_in,
    smtc_out_if.source                          torque_out
);
    import smtc_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int XW = (W > FIELD_W) ? W : FIELD_W;

    function automatic logic signed [W-1:0] sat_in(input logic [FIELD_W-1:0] x);
        logic signed [XW-1:0] xe;
        logic [XW-W:0]        top;
        xe  = XW'(signed'(x));
        top = xe[XW-1:W-1];
        if (&top || ~|top)
        begin
            return xe[W-1:0];
        end
        return xe[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    logic [FIELD_W-1:0] slope_reg, gain_reg, inertia_reg, w1_reg, w2_reg, bl_reg;
    logic [EPS_W-1:0]   eps_reg;
    q_status_t          qstat;
    logic               push, pop;
    logic signed [W-1:0] sigma_f, eq_f, sigma_q, eq_q;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg   <= '0;
            gain_reg    <= '0;
            inertia_reg <= '0;
            w1_reg      <= '0;
            w2_reg      <= '0;
            bl_reg      <= '0;
            eps_reg     <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLIDING_SLOPE:      slope_reg   <= cfg_data;
                REG_SWITCHING_GAIN:     gain_reg    <= cfg_data;
                REG_MOTOR_INERTIA:      inertia_reg <= cfg_data;
                REG_TORSION_COEFF:      w1_reg      <= cfg_data;
                REG_MOTOR_VEL_COEFF:    w2_reg      <= cfg_data;
                REG_LOAD_DAMPING_RATIO: bl_reg      <= cfg_data;
                REG_BOUNDARY_WIDTH:     eps_reg     <= cfg_data[EPS_W-1:0];
                default:                ;
            endcase
        end
    end

    smtc_front #(.W(W), .F(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .slope     (sat_in(slope_reg)),
        .w1        (sat_in(w1_reg)),
        .w2        (sat_in(w2_reg)),
        .bl        (sat_in(bl_reg)),
        .qstat     (qstat),
        .push      (push),
        .sigma     (sigma_f),
        .eq        (eq_f)
    );

    smtc_queue #(.W(W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sigma_in  (sigma_f),
        .eq_in     (eq_f),
        .pop       (pop),
        .sigma_out (sigma_q),
        .eq_out    (eq_q),
        .qstat     (qstat)
    );

    smtc_back #(.W(W), .F(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .sigma_q    (sigma_q),
        .eq_q       (eq_q),
        .pop        (pop),
        .gain       (sat_in(gain_reg)),
        .inertia    (sat_in(inertia_reg)),
        .eps        (eps_reg),
        .torque_out (torque_out)
    );

endmodule
`default_nettype wire
